// ----- rtl/atpf_pkg.sv -----
// atpf_pkg: shared types, codes and constants of the affine tile-map pixel fetch block.
// Used by atpf_xform, affine_tilemap_pixel_fetch_core and atpf_checker; depends on nothing.
`default_nettype none

package atpf_pkg;

   // video memory
   localparam int VRAM_DEPTH = 32768;
   localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
   localparam int WORD_W     = 16;

   // map layout and layer selection
   localparam int MAP_WIDTH_TILES = 128;
   localparam int MAP_SHIFT       = $clog2(MAP_WIDTH_TILES);
   localparam bit SECOND_LAYER    = 1'b0;

   // coordinate arithmetic
   localparam int COORD_W    = 10;
   localparam int SUM_W      = 32;
   localparam int FRAC_W     = 8;
   localparam int TRUNC_W    = 6;
   localparam int OFFSET_W   = 11;
   localparam int MATRIX_W   = 16;
   localparam int POS_W      = 13;

   // port widths
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 16;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_RENDER = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      WRAP_REPEAT      = 2'd0,
      WRAP_REPEAT_ALT  = 2'd1,
      WRAP_TRANSPARENT = 2'd2,
      WRAP_TILE_ZERO   = 2'd3
   } wrap_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MATRIX_A = 3'd0,
      CSR_MATRIX_B = 3'd1,
      CSR_MATRIX_C = 3'd2,
      CSR_MATRIX_D = 3'd3,
      CSR_CENTRE_X = 3'd4,
      CSR_CENTRE_Y = 3'd5,
      CSR_SCROLL_H = 3'd6,
      CSR_SCROLL_V = 3'd7
   } csr_index_type;

   typedef enum logic {
      PH_TILE  = 1'b0,
      PH_PIXEL = 1'b1
   } fetch_phase_type;

   typedef struct packed {
      logic signed [MATRIX_W-1:0] matrix_a;
      logic signed [MATRIX_W-1:0] matrix_b;
      logic signed [MATRIX_W-1:0] matrix_c;
      logic signed [MATRIX_W-1:0] matrix_d;
      logic signed [POS_W-1:0]    centre_x;
      logic signed [POS_W-1:0]    centre_y;
      logic signed [POS_W-1:0]    scroll_h;
      logic signed [POS_W-1:0]    scroll_v;
   } cfg_type;

   typedef struct packed {
      func_type            func;
      logic [VRAM_AW-1:0]  mem_addr;
      logic [WORD_W-1:0]   mem_data;
      logic [7:0]          line;
      logic [7:0]          source_x;
      logic [7:0]          screen_col;
      wrap_type            wrap_mode;
      logic [1:0]          flip_bits;
   } req_type;

   // transformed item handed to the fetch stage
   typedef struct packed {
      func_type            func;
      logic [VRAM_AW-1:0]  mem_addr;
      logic [WORD_W-1:0]   mem_data;
      logic [COORD_W-1:0]  px;
      logic [COORD_W-1:0]  py;
      logic                outside;
      wrap_type            wrap_mode;
      logic [7:0]          out_col;
   } coord_type;

endpackage

`default_nettype wire

// ----- rtl/atpf_xform.sv -----
// atpf_xform: four-stage affine coordinate pipeline (offsets, products, partial sums, coords).
// Depends on atpf_pkg; feeds the fetch stage of affine_tilemap_pixel_fetch_core.
`default_nettype none

module atpf_xform (
   input  wire                 clock,
   input  wire                 reset,
   input  atpf_pkg::cfg_type   cfg,
   input  wire                 in_valid,
   output logic                in_ready,
   input  atpf_pkg::req_type   in_item,
   output logic                out_valid,
   input  wire                 out_ready,
   output atpf_pkg::coord_type out_item
);

   localparam int SW = atpf_pkg::SUM_W;
   localparam logic [SW-1:0] TRUNC_MASK = ~SW'((1 << atpf_pkg::TRUNC_W) - 1);

   // stage 1: registered item with offsets
   logic                                  s1_valid_ff;
   atpf_pkg::func_type                    s1_func_ff;
   logic [atpf_pkg::VRAM_AW-1:0]          s1_addr_ff;
   logic [atpf_pkg::WORD_W-1:0]           s1_data_ff;
   logic [7:0]                            s1_y_ff;
   logic [7:0]                            s1_sx_ff;
   logic [7:0]                            s1_col_ff;
   atpf_pkg::wrap_type                    s1_wrap_ff;
   logic signed [atpf_pkg::OFFSET_W-1:0]  s1_dh_ff;
   logic signed [atpf_pkg::OFFSET_W-1:0]  s1_dv_ff;

   // stage 2: products
   logic                                  s2_valid_ff;
   atpf_pkg::func_type                    s2_func_ff;
   logic [atpf_pkg::VRAM_AW-1:0]          s2_addr_ff;
   logic [atpf_pkg::WORD_W-1:0]           s2_data_ff;
   logic [7:0]                            s2_col_ff;
   atpf_pkg::wrap_type                    s2_wrap_ff;
   logic signed [SW-1:0]                  s2_adh_ff, s2_bdv_ff, s2_by_ff, s2_asx_ff;
   logic signed [SW-1:0]                  s2_cdh_ff, s2_ddv_ff, s2_dy_ff, s2_csx_ff;

   // stage 3: partial sums
   logic                                  s3_valid_ff;
   atpf_pkg::func_type                    s3_func_ff;
   logic [atpf_pkg::VRAM_AW-1:0]          s3_addr_ff;
   logic [atpf_pkg::WORD_W-1:0]           s3_data_ff;
   logic [7:0]                            s3_col_ff;
   atpf_pkg::wrap_type                    s3_wrap_ff;
   logic signed [SW-1:0]                  s3_x1_ff, s3_x2_ff, s3_y1_ff, s3_y2_ff;

   // stage 4: source coordinates
   logic                                  s4_valid_ff;
   atpf_pkg::coord_type                   s4_item_ff;

   logic adv1, adv2, adv3, adv4;

   logic [atpf_pkg::POS_W:0]              diff_h, diff_v;
   logic signed [atpf_pkg::OFFSET_W-1:0]  dh_in, dv_in;
   logic [7:0]                            y_in, col_in;

   logic signed [SW-1:0] a_ext, b_ext, c_ext, d_ext;
   logic signed [SW-1:0] dh_ext, dv_ext, y_ext, sx_ext;
   logic signed [SW-1:0] cx_ext, cy_ext;
   logic signed [SW-1:0] sum_x, sum_y;

   assign adv4     = !s4_valid_ff || out_ready;
   assign adv3     = !s3_valid_ff || adv4;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // offset differences wrap to 14 bits, then keep 10 bits plus the sign of bit 13
   always_comb begin
      diff_h = {cfg.scroll_h[atpf_pkg::POS_W-1], cfg.scroll_h}
             - {cfg.centre_x[atpf_pkg::POS_W-1], cfg.centre_x};
      diff_v = {cfg.scroll_v[atpf_pkg::POS_W-1], cfg.scroll_v}
             - {cfg.centre_y[atpf_pkg::POS_W-1], cfg.centre_y};
      dh_in  = {diff_h[atpf_pkg::POS_W], diff_h[atpf_pkg::OFFSET_W-2:0]};
      dv_in  = {diff_v[atpf_pkg::POS_W], diff_v[atpf_pkg::OFFSET_W-2:0]};
      y_in   = in_item.flip_bits[1] ? 8'(8'd255 - in_item.line) : in_item.line;
      col_in = in_item.flip_bits[0] ? 8'(8'd255 - in_item.screen_col) : in_item.screen_col;
   end

   always_comb begin
      a_ext  = SW'($signed(cfg.matrix_a));
      b_ext  = SW'($signed(cfg.matrix_b));
      c_ext  = SW'($signed(cfg.matrix_c));
      d_ext  = SW'($signed(cfg.matrix_d));
      cx_ext = SW'($signed(cfg.centre_x));
      cy_ext = SW'($signed(cfg.centre_y));
      dh_ext = SW'(s1_dh_ff);
      dv_ext = SW'(s1_dv_ff);
      y_ext  = SW'($signed({1'b0, s1_y_ff}));
      sx_ext = SW'($signed({1'b0, s1_sx_ff}));
      sum_x  = s3_x1_ff + s3_x2_ff;
      sum_y  = s3_y1_ff + s3_y2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_func_ff <= in_item.func;
         s1_addr_ff <= in_item.mem_addr;
         s1_data_ff <= in_item.mem_data;
         s1_y_ff    <= y_in;
         s1_sx_ff   <= in_item.source_x;
         s1_col_ff  <= col_in;
         s1_wrap_ff <= in_item.wrap_mode;
         s1_dh_ff   <= dh_in;
         s1_dv_ff   <= dv_in;
      end
      if (adv2) begin
         s2_func_ff <= s1_func_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_data_ff <= s1_data_ff;
         s2_col_ff  <= s1_col_ff;
         s2_wrap_ff <= s1_wrap_ff;
         s2_adh_ff  <= a_ext * dh_ext;
         s2_bdv_ff  <= b_ext * dv_ext;
         s2_by_ff   <= b_ext * y_ext;
         s2_asx_ff  <= a_ext * sx_ext;
         s2_cdh_ff  <= c_ext * dh_ext;
         s2_ddv_ff  <= d_ext * dv_ext;
         s2_dy_ff   <= d_ext * y_ext;
         s2_csx_ff  <= c_ext * sx_ext;
      end
      if (adv3) begin
         s3_func_ff <= s2_func_ff;
         s3_addr_ff <= s2_addr_ff;
         s3_data_ff <= s2_data_ff;
         s3_col_ff  <= s2_col_ff;
         s3_wrap_ff <= s2_wrap_ff;
         // matrix products drop to multiples of 64; the source column term does not
         s3_x1_ff <= (s2_adh_ff & TRUNC_MASK) + (s2_bdv_ff & TRUNC_MASK)
                   + (cx_ext <<< atpf_pkg::FRAC_W);
         s3_x2_ff <= (s2_by_ff & TRUNC_MASK) + s2_asx_ff;
         s3_y1_ff <= (s2_cdh_ff & TRUNC_MASK) + (s2_ddv_ff & TRUNC_MASK)
                   + (cy_ext <<< atpf_pkg::FRAC_W);
         s3_y2_ff <= (s2_dy_ff & TRUNC_MASK) + s2_csx_ff;
      end
      if (adv4) begin
         s4_item_ff.func      <= s3_func_ff;
         s4_item_ff.mem_addr  <= s3_addr_ff;
         s4_item_ff.mem_data  <= s3_data_ff;
         s4_item_ff.wrap_mode <= s3_wrap_ff;
         s4_item_ff.out_col   <= s3_col_ff;
         s4_item_ff.px <= sum_x[atpf_pkg::FRAC_W +: atpf_pkg::COORD_W];
         s4_item_ff.py <= sum_y[atpf_pkg::FRAC_W +: atpf_pkg::COORD_W];
         // any bit at or above 1024, sign included, is off the map
         s4_item_ff.outside <=
            (sum_x[SW-1:atpf_pkg::FRAC_W+atpf_pkg::COORD_W] != '0) ||
            (sum_y[SW-1:atpf_pkg::FRAC_W+atpf_pkg::COORD_W] != '0);
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;

endmodule

`default_nettype wire

// ----- rtl/affine_tilemap_pixel_fetch_core.sv -----
// affine_tilemap_pixel_fetch_core: top level with control registers, 32K x 16 video memory
// and the fetch stage. Depends on atpf_pkg and atpf_xform.
//
// A write word (tuser 0) stores one video memory word and gives no result; a render word
// (tuser 1) gives one result word. Every memory access goes through a single port with a
// registered read: a render word holds that port for its tile-map read, then the dependent
// pixel read, before the fetch stage takes the next word, while write words use it for a
// single write and pixels outside in transparent or tile-zero mode skip the tile-map read.
// A result passes through the transform stages, the fetch stage, the data-return stage
// and the output register, and back-pressure can hold it. The memory has no reset
// clearing pass: words read before being written return arbitrary data. The user must
// write control registers only while no word is in flight; the block does not enforce it.
`default_nettype none

module affine_tilemap_pixel_fetch_core (
   input  wire                                   clock,
   input  wire                                   reset,
   // request: tdata = mem_addr, mem_data, line, source_x, screen_col, wrap_mode, flip_bits,
   // zero pad; tuser = func
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [atpf_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire                                   req_tuser,
   // response: tdata = colour_index, out_col; tuser = transparent, priority_select
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [atpf_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [atpf_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   // control register writes
   input  wire                                   csr_we,
   input  wire  [atpf_pkg::CSR_AW-1:0]           csr_addr,
   input  wire  [atpf_pkg::CSR_DW-1:0]           csr_wdata
);

   localparam int AW = atpf_pkg::VRAM_AW;

   atpf_pkg::cfg_type     cfg_ff;
   atpf_pkg::req_type     req_item;
   atpf_pkg::coord_type   xf_item;
   logic                  xf_valid;

   // fetch stage
   logic                        f_valid_ff, f_valid_in;
   atpf_pkg::coord_type         f_item_ff;
   atpf_pkg::fetch_phase_type   f_phase_ff, f_phase_in;
   logic                        f_ready, f_done, f_to_r;
   logic                        f_blank, f_tile0;

   // data-return stage
   logic                        r_valid_ff;
   logic                        r_blank_ff;
   logic [7:0]                  r_col_ff;
   logic                        r_adv;

   // output register
   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_colour_ff;
   logic [7:0]                  rsp_col_ff;
   logic                        rsp_transp_ff;
   logic                        rsp_prio_ff;
   logic                        out_free;

   // memory port
   logic [atpf_pkg::WORD_W-1:0] vram [atpf_pkg::VRAM_DEPTH];
   logic [atpf_pkg::WORD_W-1:0] q_ff;
   logic                        mem_we, mem_re;
   logic [AW-1:0]               mem_addr;
   logic [AW-1:0]               tile_addr, pix_addr;
   logic [7:0]                  tile_num;

   logic [7:0]                  pal_raw, pal;
   logic                        prio;

   // request unpacking, first field lowest
   always_comb begin
      req_item.func       = atpf_pkg::func_type'(req_tuser);
      req_item.mem_addr   = req_tdata[14:0];
      req_item.mem_data   = req_tdata[30:15];
      req_item.line       = req_tdata[38:31];
      req_item.source_x   = req_tdata[46:39];
      req_item.screen_col = req_tdata[54:47];
      req_item.wrap_mode  = atpf_pkg::wrap_type'(req_tdata[56:55]);
      req_item.flip_bits  = req_tdata[58:57];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (atpf_pkg::csr_index_type'(csr_addr))
            atpf_pkg::CSR_MATRIX_A: cfg_ff.matrix_a <= csr_wdata;
            atpf_pkg::CSR_MATRIX_B: cfg_ff.matrix_b <= csr_wdata;
            atpf_pkg::CSR_MATRIX_C: cfg_ff.matrix_c <= csr_wdata;
            atpf_pkg::CSR_MATRIX_D: cfg_ff.matrix_d <= csr_wdata;
            atpf_pkg::CSR_CENTRE_X: cfg_ff.centre_x <= csr_wdata[atpf_pkg::POS_W-1:0];
            atpf_pkg::CSR_CENTRE_Y: cfg_ff.centre_y <= csr_wdata[atpf_pkg::POS_W-1:0];
            atpf_pkg::CSR_SCROLL_H: cfg_ff.scroll_h <= csr_wdata[atpf_pkg::POS_W-1:0];
            atpf_pkg::CSR_SCROLL_V: cfg_ff.scroll_v <= csr_wdata[atpf_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   atpf_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (xf_valid),
      .out_ready (f_ready),
      .out_item  (xf_item)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign r_adv    = !r_valid_ff || out_free;

   always_comb begin
      f_blank   = f_item_ff.outside && (f_item_ff.wrap_mode == atpf_pkg::WRAP_TRANSPARENT);
      f_tile0   = f_item_ff.outside && (f_item_ff.wrap_mode == atpf_pkg::WRAP_TILE_ZERO);
      tile_addr = AW'((AW'(f_item_ff.py[atpf_pkg::COORD_W-1:3]) << atpf_pkg::MAP_SHIFT)
                + AW'(f_item_ff.px[atpf_pkg::COORD_W-1:3]));
      tile_num  = f_tile0 ? 8'd0 : q_ff[7:0];
      pix_addr  = AW'({tile_num, f_item_ff.py[2:0], f_item_ff.px[2:0]});
   end

   // fetch sequencing: writes do one memory write, renders a tile read then a pixel read
   always_comb begin
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = f_item_ff.mem_addr;
      f_done     = 1'b0;
      f_to_r     = 1'b0;
      f_phase_in = f_phase_ff;
      if (f_valid_ff) begin
         if (f_item_ff.func == atpf_pkg::FUNC_WRITE) begin
            mem_we = 1'b1;
            f_done = 1'b1;
         end else begin
            case (f_phase_ff)
               atpf_pkg::PH_TILE: begin
                  // read data register must be free before it is overwritten
                  if (r_adv) begin
                     mem_re     = 1'b1;
                     mem_addr   = tile_addr;
                     f_phase_in = atpf_pkg::PH_PIXEL;
                  end
               end
               atpf_pkg::PH_PIXEL: begin
                  if (r_adv) begin
                     mem_re   = !f_blank;
                     mem_addr = pix_addr;
                     f_done   = 1'b1;
                     f_to_r   = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
      f_ready    = !f_valid_ff || f_done;
      f_valid_in = f_ready ? xf_valid : f_valid_ff;
      if (f_ready) begin
         // off-map pixels in transparent or tile-zero mode skip the tile-map read
         f_phase_in = (xf_item.outside && (xf_item.wrap_mode == atpf_pkg::WRAP_TRANSPARENT
                       || xf_item.wrap_mode == atpf_pkg::WRAP_TILE_ZERO))
                      ? atpf_pkg::PH_PIXEL : atpf_pkg::PH_TILE;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) vram[mem_addr] <= f_item_ff.mem_data;
      if (mem_re) q_ff <= vram[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         f_phase_ff <= atpf_pkg::PH_TILE;
         r_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
         f_phase_ff <= f_phase_in;
         if (r_adv) r_valid_ff <= f_to_r;
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready) f_item_ff <= xf_item;
      if (r_adv) begin
         r_blank_ff <= f_blank;
         r_col_ff   <= f_item_ff.out_col;
      end
   end

   always_comb begin
      pal_raw = r_blank_ff ? 8'd0 : q_ff[atpf_pkg::WORD_W-1:8];
      if (atpf_pkg::SECOND_LAYER) begin
         prio = pal_raw[7];
         pal  = pal_raw & 8'h7f;
      end else begin
         prio = 1'b0;
         pal  = pal_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_colour_ff <= pal;
         rsp_transp_ff <= (pal == 8'd0);
         rsp_prio_ff   <= prio;
         rsp_col_ff    <= r_col_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_colour_ff};
   assign rsp_tuser  = {rsp_prio_ff, rsp_transp_ff};

endmodule

`default_nettype wire

// ----- rtl/atpf_checker.sv -----
// atpf_checker: port-level assertions for affine_tilemap_pixel_fetch_core, bound to the top.
// Depends on atpf_pkg.
`default_nettype none

module atpf_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [atpf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire [atpf_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // transparent flag agrees with the colour index
   a_transp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[7:0] == 8'd0)))
      else $error("transparent flag does not match colour index");

   // first layer never sets priority; second layer keeps a seven-bit index
   a_layer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (atpf_pkg::SECOND_LAYER ? !rsp_tdata[7] : !rsp_tuser[1]))
      else $error("priority or index bit wrong for layer");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word right after reset");

   // when reset first samples low, the request side is ready or no word is offered
   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_tready || !req_tvalid || req_tready)
      else $error("request side not ready after reset");

endmodule

bind affine_tilemap_pixel_fetch_core atpf_checker u_atpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
